// File: rtl/circular_deque_buffer_macros.svh
// assertion macros for the circular deque buffer
`ifndef CIRCULAR_DEQUE_BUFFER_MACROS_SVH
`define CIRCULAR_DEQUE_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define CDB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDB_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CDB_ASSERT(label, clk, rst, prop, msg)
`define CDB_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: rtl/cdb_pkg.sv
// shared types and constants of the circular deque buffer
package cdb_pkg;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 7;

   localparam logic [1:0] CMD_APPEND     = 2'd0;
   localparam logic [1:0] CMD_DROP_FRONT = 2'd1;
   localparam logic [1:0] CMD_DROP_BACK  = 2'd2;
   localparam logic [1:0] CMD_LIST       = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] element;
      logic                     last_of_run;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;
endpackage

// File: rtl/cdb_store.sv
// element memory: one write port, one registered read port
module cdb_store #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [cdb_pkg::DATA_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic [cdb_pkg::DATA_W-1:0] rdata
);
   import cdb_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/cdb_ctrl.sv
// command sequencer, ring pointers and result register
`include "circular_deque_buffer_macros.svh"
module cdb_ctrl #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cdb_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cdb_pkg::rsp_type           rsp_data,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [cdb_pkg::DATA_W-1:0] mem_wdata,
   output logic [AW-1:0]              mem_raddr,
   input  logic [cdb_pkg::DATA_W-1:0] mem_rdata
);
   import cdb_pkg::*;

   localparam logic [AW:0]      DEPTH_S = (AW+1)'(DEPTH);
   localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LIST} state_type;

   state_type        state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [OCC_W-1:0] count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_free;
   logic             list_last;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[AW-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_last = (OCC_W'(idx_ff) + OCC_W'(1)) == count_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = wrap_add(front_ff, count_ff[AW-1:0]);
      mem_wdata    = cmd_ff.value;
      mem_raddr    = pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mem_raddr = front_ff;
            if (cmd_ff.command == CMD_LIST && count_ff != '0) begin
               pos_in   = front_ff;
               idx_in   = '0;
               state_in = S_LIST;
            end else if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.element     = '0;
               rsp_in.last_of_run = 1'b1;
               rsp_in.status      = ST_OK;
               state_in           = S_IDLE;
               case (cmd_ff.command)
                  CMD_APPEND: begin
                     if (count_ff == DEPTH_C) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + OCC_W'(1);
                     end
                  end
                  CMD_DROP_FRONT: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        front_in = wrap_add(front_ff, AW'(1));
                        count_in = count_ff - OCC_W'(1);
                     end
                  end
                  CMD_DROP_BACK: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - OCC_W'(1);
                     end
                  end
                  default: begin
                     rsp_in.status = ST_EMPTY;
                  end
               endcase
               rsp_in.occupancy = count_in;
            end
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.element     = mem_rdata;
               rsp_in.last_of_run = list_last;
               rsp_in.occupancy   = count_ff;
               if (list_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  pos_in = wrap_add(pos_ff, AW'(1));
               end
               mem_raddr = pos_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CDB_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > DEPTH_C, "count above depth")
   `CDB_ASSERT(a_occ_match, clock, reset, rsp_valid_ff |-> rsp_ff.occupancy == count_ff, "occupancy mismatch")
   `CDB_ASSERT(a_full_only_full, clock, reset, (rsp_valid_ff && rsp_ff.status == ST_FULL) |-> count_ff == DEPTH_C, "full reported when not full")
   `CDB_ASSERT_NEVER(a_list_nonempty, clock, reset, state_ff == S_LIST && count_ff == '0, "listing an empty store")
endmodule

// File: rtl/circular_deque_buffer.sv
// top level of the circular deque buffer
// Bounded double-ended queue of signed 32-bit elements held in a ring buffer.
// Request channel (req_valid/req_stall/req_data): command 0 appends value at
// the back, 1 drops the front element, 2 drops the back element, 3 lists all
// elements from front to back.
// Response channel (rsp_valid/rsp_stall/rsp_data): status, element,
// last_of_run and occupancy after the operation. Append and drop give one
// response; list gives one response per stored element, the final one marked
// by last_of_run, or a single empty response when nothing is stored.
// A request is held in an input register and the next one is taken as soon as
// the previous one has left its last response in the output register.
// Append and drop pass through S_EXEC, whose response is registered once the output register is free.
// List: the registered read of the element memory starts in S_EXEC, and the
// memory then streams one element per cycle while rsp_stall is low.
// Reset clears the front pointer, the count and the response valid; memory
// contents are not cleared. A stalled receiver holds the response register
// and the memory read address, so nothing is lost while rsp_stall is high.
module circular_deque_buffer #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cdb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdb_pkg::rsp_type rsp_data
);
   import cdb_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [DATA_W-1:0] mem_rdata;

   cdb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   cdb_store #(.DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );
endmodule
